// ===== sv/chained_hash_map_core_macros.svh =====
// Assertion macros shared by the chained hash map core.
// Included by the top level; depends on nothing else.
`ifndef CHAINED_HASH_MAP_CORE_MACROS_SVH
`define CHAINED_HASH_MAP_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/chm_pkg.sv =====
// Package for the chained hash map: status codes and controller commands.
// No dependencies.
`timescale 1ns / 1ps
package chm_pkg;
  localparam int unsigned KeyW = 31;
  localparam int unsigned ValW = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned BucketOutW = 4;
  localparam int unsigned CountW = 5;
  localparam logic [CountW-1:0] CountReset = 5'd5;

  typedef enum logic [2:0] {
    ST_FOUND = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL = 3'd4
  } status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture request, start modulo
    logic mod_step;   // one restoring-subtract step
    logic head_rd;    // read bucket head into walk pointer
    logic node_rd;    // issue node memory read at pointer
    logic advance;    // follow the link of the read node
    logic alloc;      // write new node and update head
    logic set_result; // capture result
    status_t status;
  } chm_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic mod_done;
    logic is_lookup;
    logic ptr_valid;  // walk pointer names a node
    logic key_match;  // read node key matches
    logic pool_full;
  } chm_stat_t;
endpackage

// ===== sv/chm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module chm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/chm_ctrl.sv =====
// Controller state machine for the chained hash map.
// Depends on chm_pkg.
`timescale 1ns / 1ps
module chm_ctrl #(
  parameter int unsigned POOL_NODES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              idle,
  input  chm_pkg::chm_stat_t stat,
  output chm_pkg::chm_cmd_t  cmd
);
  localparam int unsigned StepW = $clog2(POOL_NODES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_HEAD, S_READ, S_CMP, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [StepW-1:0] steps_r, steps_nxt;

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign idle = (state_r == S_IDLE) && !out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    steps_nxt = steps_r;
    cmd = '0;
    cmd.status = chm_pkg::ST_NOT_FOUND;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (stat.mod_done) begin
          state_nxt = S_HEAD;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_HEAD: begin
        cmd.head_rd = 1'b1;
        steps_nxt = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        if (stat.ptr_valid && steps_r < StepW'(POOL_NODES)) begin
          cmd.node_rd = 1'b1;
          state_nxt = S_CMP;
        end else begin
          // Chain ends, or the step bound is reached, without a match.
          cmd.set_result = 1'b1;
          state_nxt = S_DONE;
          if (stat.is_lookup) begin
            cmd.status = chm_pkg::ST_NOT_FOUND;
          end else if (stat.pool_full) begin
            cmd.status = chm_pkg::ST_FULL;
          end else begin
            cmd.status = chm_pkg::ST_INSERTED;
            cmd.alloc = 1'b1;
          end
        end
      end
      S_CMP: begin
        if (stat.key_match) begin
          cmd.set_result = 1'b1;
          cmd.status = stat.is_lookup ? chm_pkg::ST_FOUND : chm_pkg::ST_DUPLICATE;
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r <= steps_nxt;
    end
  end
endmodule

// ===== sv/chm_datapath.sv =====
// Datapath for the chained hash map: modulo unit, bucket heads, node pool.
// Depends on chm_pkg and chm_ram.
`timescale 1ns / 1ps
module chm_datapath #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned POOL_NODES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [chm_pkg::CountW-1:0]        bucket_count,
  input  logic                              in_operation,
  input  logic [chm_pkg::KeyW-1:0]          in_key,
  input  logic signed [chm_pkg::ValW-1:0]   in_data_value,
  input  chm_pkg::chm_cmd_t                 cmd,
  output chm_pkg::chm_stat_t                stat,
  output logic [chm_pkg::StatusW-1:0]       out_status,
  output logic signed [chm_pkg::ValW-1:0]   out_found_value,
  output logic [chm_pkg::BucketOutW-1:0]    out_bucket
);
  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned NW = $clog2(POOL_NODES);
  localparam int unsigned UW = $clog2(POOL_NODES + 1);
  localparam int unsigned KW = chm_pkg::KeyW;
  localparam int unsigned VW = chm_pkg::ValW;
  localparam int unsigned MW = KW + 1;
  localparam int unsigned MaxB = (NUM_BUCKETS < 16) ? NUM_BUCKETS : 16;

  logic              op_r;
  logic [KW-1:0]     key_r;
  logic [VW-1:0]     val_r;
  logic [KW-1:0]     rem_r;
  logic [KW-1:0]     quo_r;
  logic [4:0]        div_r;
  logic [4:0]        mod_cnt_r;
  logic [NW-1:0]     ptr_r;
  logic              ptr_ok_r;
  logic [UW-1:0]     used_r;
  logic [NW-1:0]     head_r [NUM_BUCKETS];
  logic              head_ok_r [NUM_BUCKETS];
  logic [chm_pkg::StatusW-1:0] status_r;
  logic [VW-1:0]     found_r;
  logic [KW-1:0]     rd_key;
  logic [VW-1:0]     rd_val;
  logic [NW:0]       rd_link;
  logic [MW-1:0]     trial;
  logic [4:0]        eff;
  logic [BW-1:0]     bkt;

  // Clamp the configured bucket count to the usable range.
  always_comb begin
    if (bucket_count == '0) begin
      eff = 5'd1;
    end else if (bucket_count > 5'(MaxB)) begin
      eff = 5'(MaxB);
    end else begin
      eff = bucket_count;
    end
  end

  // Restoring division, one quotient bit per step; only the remainder is kept, quo_r holds the shifted key.
  assign trial = {rem_r, quo_r[KW-1]} - MW'(div_r);
  assign bkt = BW'(rem_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      key_r <= in_key;
      val_r <= in_data_value;
      rem_r <= '0;
      quo_r <= in_key;
      div_r <= eff;
    end else if (cmd.mod_step) begin
      if (!trial[MW-1]) begin
        rem_r <= trial[KW-1:0];
      end else begin
        rem_r <= {rem_r[KW-2:0], quo_r[KW-1]};
      end
      quo_r <= {quo_r[KW-2:0], 1'b0};
    end
  end

  // Step counter for the modulo unit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r <= '0;
    end else if (cmd.load) begin
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
  end

  // Bucket head valid bits and pool count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        head_ok_r[i] <= 1'b0;
      end
    end else if (cmd.alloc) begin
      used_r <= used_r + 1'b1;
      head_ok_r[bkt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      head_r[bkt] <= NW'(used_r);
    end
  end

  // Walk pointer; the link word carries its own valid bit on top.
  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      ptr_r <= head_r[bkt];
      ptr_ok_r <= head_ok_r[bkt];
    end else if (cmd.advance) begin
      ptr_r <= rd_link[NW-1:0];
      ptr_ok_r <= rd_link[NW];
    end
  end

  // Node pool memories.
  chm_ram #(.WIDTH(KW), .DEPTH(POOL_NODES)) u_key (
    .clk(clk), .we(cmd.alloc), .waddr(NW'(used_r)), .wdata(key_r),
    .raddr(ptr_r), .rdata(rd_key));
  chm_ram #(.WIDTH(VW), .DEPTH(POOL_NODES)) u_val (
    .clk(clk), .we(cmd.alloc), .waddr(NW'(used_r)), .wdata(val_r),
    .raddr(ptr_r), .rdata(rd_val));
  chm_ram #(.WIDTH(NW + 1), .DEPTH(POOL_NODES)) u_link (
    .clk(clk), .we(cmd.alloc), .waddr(NW'(used_r)),
    .wdata({head_ok_r[bkt], head_r[bkt]}),
    .raddr(ptr_r), .rdata(rd_link));

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      status_r <= cmd.status;
      found_r <= (cmd.status == chm_pkg::ST_FOUND) ? rd_val : '0;
    end
  end

  assign stat.mod_done = (mod_cnt_r == 5'(KW));
  assign stat.is_lookup = (op_r == chm_pkg::OP_LOOKUP);
  assign stat.ptr_valid = ptr_ok_r;
  assign stat.key_match = (rd_key == key_r);
  assign stat.pool_full = (used_r >= UW'(POOL_NODES));

  assign out_status = status_r;
  assign out_found_value = found_r;
  assign out_bucket = 4'(rem_r);
endmodule

// ===== sv/chained_hash_map_core.sv =====
// Top level of the chained hash map core.
// Depends on chm_pkg, chm_ctrl, chm_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "chained_hash_map_core_macros.svh"

// A key-value map with separate chaining over a fixed node pool. Each request
// (insert or lookup) gives one result. A request is accepted, runs 31 steps in
// the bit-serial modulo unit and a check that it has finished, then reads the
// bucket head, then for each chain node visited does one registered pool
// memory read and one compare, and sets the result after a match or after the
// chain ends. The next request is accepted once the previous result has been
// taken.
module chained_hash_map_core #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned POOL_NODES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [chm_pkg::KeyW-1:0]            in_key,
  input  logic signed [chm_pkg::ValW-1:0]     in_data_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [chm_pkg::StatusW-1:0]         out_status,
  output logic signed [chm_pkg::ValW-1:0]     out_found_value,
  output logic [chm_pkg::BucketOutW-1:0]      out_bucket,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [chm_pkg::CountW-1:0]          cfg_bucket_count
);
  chm_pkg::chm_cmd_t  cmd;
  chm_pkg::chm_stat_t stat;
  logic idle;
  logic [chm_pkg::CountW-1:0] bucket_count_r;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= chm_pkg::CountReset;
    end else if (cfg_valid && cfg_ready) begin
      bucket_count_r <= cfg_bucket_count;
    end
  end

  chm_ctrl #(.POOL_NODES(POOL_NODES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .idle(idle),
    .stat(stat), .cmd(cmd));

  chm_datapath #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
    .clk(clk), .rst_n(rst_n), .bucket_count(bucket_count_r),
    .in_operation(in_operation), .in_key(in_key), .in_data_value(in_data_value),
    .cmd(cmd), .stat(stat), .out_status(out_status),
    .out_found_value(out_found_value), .out_bucket(out_bucket));

  // Only one request is in flight.
  `CHM_ASSERT_IMP(a_no_accept_busy, clk, rst_n, !idle, in_stall)
  // A node is only allocated when the pool has room.
  `CHM_ASSERT_IMP(a_alloc_room, clk, rst_n, cmd.alloc, !stat.pool_full)
  // A found value is zero unless the status is found.
  `CHM_ASSERT_IMP(a_found_zero, clk, rst_n,
    out_valid && (out_status != chm_pkg::ST_FOUND), out_found_value == '0)
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the chained hash map core.
// Depends on chm_pkg and chained_hash_map_core; predicts each result in-line.
`timescale 1ns / 1ps

module tb_top;
  import chm_pkg::*;

  localparam int NB = 16;
  localparam int NP = 64;

  typedef struct packed {
    logic             op;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  val;
  } map_req_t;

  typedef struct packed {
    logic [StatusW-1:0]    status;
    logic [ValW-1:0]       value;
    logic [BucketOutW-1:0] bucket;
  } map_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic [KeyW-1:0] in_key = '0;
  logic signed [ValW-1:0] in_data_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [StatusW-1:0] out_status;
  logic signed [ValW-1:0] out_found_value;
  logic [BucketOutW-1:0] out_bucket;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CountW-1:0] cfg_bucket_count = '0;
  logic acc_seen = 1'b0;

  chained_hash_map_core #(.NUM_BUCKETS(NB), .POOL_NODES(NP)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_key(in_key), .in_data_value(in_data_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_found_value(out_found_value), .out_bucket(out_bucket),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_bucket_count(cfg_bucket_count)
  );

  always #5 clk = ~clk;

  // Predictor state, a private copy of the map.
  logic [CountW-1:0] map_count;
  int unsigned head_idx [NB];
  bit          head_ok  [NB];
  logic [KeyW-1:0] pool_key [NP];
  logic [ValW-1:0] pool_val [NP];
  int unsigned     pool_link [NP];
  bit              pool_link_ok [NP];
  int unsigned     pool_used;

  map_req_t pending_reqs[$];
  map_rsp_t expected_rsps[$];
  int errors = 0;
  bit quiet_tail = 1'b0;
  bit hold_long = 1'b0;
  int stim_gap = 0;
  int sink_gap = 0;
  int hold_cnt = 0;

  task automatic report_mismatch(input string what, input logic [ValW-1:0] got,
                                 input logic [ValW-1:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic void map_clear();
    map_count = CountReset;
    pool_used = 0;
    for (int i = 0; i < NB; i++) head_ok[i] = 1'b0;
  endfunction

  // Walks one chain; returns 1 and the node on a key match.
  function automatic bit chain_find(input int unsigned b, input logic [KeyW-1:0] k,
                                    output int unsigned hit);
    bit ok;
    int unsigned idx;
    int steps;
    ok = head_ok[b];
    idx = head_idx[b];
    steps = 0;
    hit = 0;
    while (ok && idx < NP && steps < NP) begin
      if (pool_key[idx] == k) begin
        hit = idx;
        return 1'b1;
      end
      ok = pool_link_ok[idx];
      idx = pool_link[idx];
      steps++;
    end
    return 1'b0;
  endfunction

  // Computes the result of one request and updates the map copy.
  function automatic map_rsp_t map_apply(input map_req_t r);
    map_rsp_t o;
    int unsigned nb, b, hit;
    nb = map_count;
    if (nb == 0) nb = 1;
    if (nb > NB) nb = NB;
    b = r.key % nb;
    o.value = '0;
    o.bucket = b[BucketOutW-1:0];
    if (r.op == OP_LOOKUP) begin
      if (chain_find(b, r.key, hit)) begin
        o.status = ST_FOUND;
        o.value = pool_val[hit];
      end else begin
        o.status = ST_NOT_FOUND;
      end
    end else if (chain_find(b, r.key, hit)) begin
      o.status = ST_DUPLICATE;
    end else if (pool_used >= NP) begin
      o.status = ST_FULL;
    end else begin
      pool_key[pool_used] = r.key;
      pool_val[pool_used] = r.val;
      pool_link[pool_used] = head_idx[b];
      pool_link_ok[pool_used] = head_ok[b];
      head_idx[b] = pool_used;
      head_ok[b] = 1'b1;
      pool_used++;
      o.status = ST_INSERTED;
    end
    return o;
  endfunction

  // The handshake is sampled at the rising edge, before the block updates stall.
  always @(posedge clk) acc_seen <= in_valid && !in_stall && rst_n;

  // Request driver: offers queued requests with random gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      if (acc_seen) begin
        expected_rsps.push_back(map_apply({in_operation, in_key, in_data_value}));
      end
      if (!in_valid || acc_seen) begin
        if (stim_gap > 0) begin
          stim_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          map_req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_operation <= r.op;
          in_key <= r.key;
          in_data_value <= r.val;
          if (!quiet_tail && $urandom_range(0, 7) == 0) stim_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random stall bursts and one long hold-off.
  always @(negedge clk) begin
    if (hold_long) begin
      out_stall <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet_tail && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 12);
    end
  end

  // Long hold-off counted in its own process.
  always @(negedge clk) begin
    if (hold_long) begin
      hold_cnt++;
      if (hold_cnt >= 400) hold_long = 1'b0;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result", ValW'(out_status), '0);
      end else begin
        map_rsp_t e;
        e = expected_rsps.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", ValW'(out_status), ValW'(e.status));
        if (out_found_value !== e.value)
          report_mismatch("found_value", out_found_value, e.value);
        if (out_bucket !== e.bucket)
          report_mismatch("bucket", ValW'(out_bucket), ValW'(e.bucket));
      end
    end
  end

  task automatic add_req(input logic op, input logic [KeyW-1:0] k,
                         input logic [ValW-1:0] v);
    pending_reqs.push_back('{op: op, key: k, val: v});
  endtask

  // Waits until every queued request is accepted and every result has come.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_count(input logic [CountW-1:0] c);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_bucket_count <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    map_count = c;
  endtask

  // Random phase; keys mostly from a small set so hits and duplicates occur.
  task automatic random_phase(input int n);
    logic [KeyW-1:0] k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: k = KeyW'($urandom());
        1: k = KeyW'('h7fff_ffff - $urandom_range(0, 40));
        default: k = KeyW'($urandom_range(0, 60));
      endcase
      add_req(1'($urandom_range(0, 1)), k, $urandom());
    end
  endtask

  initial begin
    map_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, duplicate, lookups hit and miss, default count.
    add_req(OP_INSERT, '0, 32'h8000_0000);
    add_req(OP_INSERT, '1, 32'h7fff_ffff);
    add_req(OP_INSERT, 31'd5, 32'hffff_ffff);
    add_req(OP_INSERT, '0, 32'h1234_5678);
    add_req(OP_LOOKUP, '0, 32'hffff_ffff);
    add_req(OP_LOOKUP, '1, '0);
    add_req(OP_LOOKUP, 31'd5, '0);
    add_req(OP_LOOKUP, 31'd10, '0);
    add_req(OP_LOOKUP, 31'h5555_5555, 32'haaaa_aaaa);
    drain();

    // Zero count acts as one bucket; earlier chains are left behind.
    write_count(5'd0);
    add_req(OP_LOOKUP, '0, '0);
    add_req(OP_INSERT, 31'h2aaa_aaaa, 32'h5555_5555);
    add_req(OP_LOOKUP, 31'h2aaa_aaaa, '0);
    drain();

    // Count above the bucket array is clipped.
    write_count(5'd31);
    add_req(OP_INSERT, 31'd17, 32'd1);
    add_req(OP_LOOKUP, 31'd17, '0);
    add_req(OP_LOOKUP, '1, '0);
    drain();

    write_count(5'd16);
    random_phase(150);
    drain();
    write_count(5'd1);
    random_phase(120);
    drain();

    // Fill past the pool, then a duplicate while full.
    write_count(5'd7);
    for (int i = 0; i < NP; i++) add_req(OP_INSERT, 31'(1000 + i), $urandom());
    add_req(OP_INSERT, 31'd1000, '0);
    add_req(OP_INSERT, 31'd999, '0);
    // Long receiver hold while requests keep coming.
    hold_long = 1'b1;
    random_phase(200);
    drain();

    write_count(5'd3);
    random_phase(150);
    drain();

    quiet_tail = 1'b1;
    write_count(5'd5);
    random_phase(60);
    drain();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
